// File: sv/twiddle_gain_tuner_defines.svh
// ----------------------------------------------------------------------------
// twiddle gain tuner assertion macros
// shared concurrent assertion forms, clocked on i_clk, held off in reset
// ----------------------------------------------------------------------------
`ifndef TWIDDLE_GAIN_TUNER_DEFINES_SVH
`define TWIDDLE_GAIN_TUNER_DEFINES_SVH

// property that holds at every edge
`define TWG_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// property checked in the same cycle as its trigger
`define TWG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property checked in the cycle after its trigger
`define TWG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/twg_pkg.sv
// ----------------------------------------------------------------------------
// twiddle gain tuner package
// constants, register indexes, shared types and arithmetic helpers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package twg_pkg;

    localparam logic [7:0]  ROUND_LEN      = 8'd100;
    localparam logic [15:0] MAX_ROUNDS     = 16'd1000;
    localparam logic [33:0] STEP_TOLERANCE = 34'd13107;

    localparam logic [30:0] RST_INIT_STEP = 31'd65536;
    localparam logic [15:0] RST_GROW      = 16'd18022;
    localparam logic [15:0] RST_SHRINK    = 16'd14746;

    typedef enum logic [3:0] {
        CFG_INIT_GAIN_P = 4'd0,
        CFG_INIT_GAIN_I = 4'd1,
        CFG_INIT_GAIN_D = 4'd2,
        CFG_INIT_STEP_P = 4'd3,
        CFG_INIT_STEP_I = 4'd4,
        CFG_INIT_STEP_D = 4'd5,
        CFG_GROW        = 4'd6,
        CFG_SHRINK      = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0][31:0] init_gain;
        logic [2:0][30:0] init_step;
        logic [15:0]      grow;
        logic [15:0]      shrink;
    } t_cfg;

    typedef struct packed {
        logic [31:0] gain_p;
        logic [31:0] gain_i;
        logic [31:0] gain_d;
        logic        tuning_active;
        logic        round_ended;
    } t_result;

    // clamp a 35-bit two's complement value to signed 32 bits
    function automatic logic [31:0] sat_gain(input logic [34:0] v);
        logic [31:0] r;
        if (v[34:31] != {4{v[34]}}) begin
            r = v[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] gain_add(input logic [31:0] g, input logic [31:0] s);
        return sat_gain({{3{g[31]}}, g} + {3'b000, s});
    endfunction

    function automatic logic [31:0] gain_sub2(input logic [31:0] g, input logic [31:0] s);
        return sat_gain({{3{g[31]}}, g} - {2'b00, s, 1'b0});
    endfunction

    // step * factor in Q2.14, truncated and clamped to 32 bits
    function automatic logic [31:0] scale_step(input logic [31:0] s, input logic [15:0] f);
        logic [47:0] p;
        logic [31:0] r;
        p = {16'b0, s} * {32'b0, f};
        if (p[47:46] != 2'b00) begin
            r = '1;
        end else begin
            r = p[45:14];
        end
        return r;
    endfunction

    function automatic logic can_run(input logic [31:0] s0, input logic [31:0] s1,
                                     input logic [31:0] s2, input logic [15:0] rounds);
        logic [33:0] sum;
        sum = {2'b00, s0} + {2'b00, s1} + {2'b00, s2};
        return (sum > STEP_TOLERANCE) && (rounds < MAX_ROUNDS);
    endfunction

endpackage

`default_nettype wire

// File: sv/twg_cfg_regs.sv
// ----------------------------------------------------------------------------
// twiddle gain tuner configuration registers
// write-only register file; any write to a defined index requests a search restart
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twg_cfg_regs import twg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [3:0]  i_idx,
    input  logic [31:0] i_data,
    output t_cfg        o_cfg,
    output logic        o_restart
);

    t_cfg r_cfg, n_cfg;
    logic r_restart, n_restart;

    always_comb begin
        n_cfg     = r_cfg;
        n_restart = 1'b0;
        if (i_wr_en) begin
            n_restart = 1'b1;
            case (i_idx)
                CFG_INIT_GAIN_P: n_cfg.init_gain[0] = i_data;
                CFG_INIT_GAIN_I: n_cfg.init_gain[1] = i_data;
                CFG_INIT_GAIN_D: n_cfg.init_gain[2] = i_data;
                CFG_INIT_STEP_P: n_cfg.init_step[0] = i_data[30:0];
                CFG_INIT_STEP_I: n_cfg.init_step[1] = i_data[30:0];
                CFG_INIT_STEP_D: n_cfg.init_step[2] = i_data[30:0];
                CFG_GROW:        n_cfg.grow         = i_data[15:0];
                CFG_SHRINK:      n_cfg.shrink       = i_data[15:0];
                default:         n_restart          = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_gain <= '0;
            r_cfg.init_step <= {3{RST_INIT_STEP}};
            r_cfg.grow      <= RST_GROW;
            r_cfg.shrink    <= RST_SHRINK;
            r_restart       <= 1'b0;
        end else begin
            r_cfg     <= n_cfg;
            r_restart <= n_restart;
        end
    end

    assign o_cfg     = r_cfg;
    assign o_restart = r_restart;

endmodule

`default_nettype wire

// File: sv/twg_core.sv
// ----------------------------------------------------------------------------
// twiddle gain tuner core
// per-sample error accumulation and coordinate descent over three gains
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "twiddle_gain_tuner_defines.svh"

module twg_core import twg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_restart,
    input  t_cfg        i_cfg,
    input  logic        i_adv,
    input  logic [31:0] i_sample,
    output t_result     o_result
);

    logic [31:0] r_gain [3];
    logic [31:0] n_gain [3];
    logic [31:0] r_step [3];
    logic [31:0] n_step [3];
    logic [2:0]  r_first, n_first;
    logic [1:0]  r_idx, n_idx;
    logic [7:0]  r_cnt, n_cnt;
    logic [39:0] r_sum, n_sum;
    logic [39:0] r_best, n_best;
    logic        r_base, n_base;
    logic [15:0] r_rounds, n_rounds;

    logic        run;
    logic        ended;
    logic        better;
    logic [32:0] mag;
    logic [39:0] acc;
    logic [7:0]  cnt_inc;
    logic [1:0]  nx;
    logic [31:0] scaled;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_gain[k] = r_gain[k];
            n_step[k] = r_step[k];
        end
        n_first  = r_first;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_sum    = r_sum;
        n_best   = r_best;
        n_base   = r_base;
        n_rounds = r_rounds;
        ended    = 1'b0;

        run     = can_run(r_step[0], r_step[1], r_step[2], r_rounds);
        nx      = (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
        mag     = i_sample[31] ? 33'd0 - {i_sample[31], i_sample} : {1'b0, i_sample};
        acc     = r_sum + {7'd0, mag};
        cnt_inc = r_cnt + 8'd1;
        better  = acc < r_best;
        scaled  = scale_step(r_step[r_idx], better ? i_cfg.grow : i_cfg.shrink);

        if (i_adv && run) begin
            n_sum = acc;
            n_cnt = cnt_inc;
            if (cnt_inc >= ROUND_LEN) begin
                ended = 1'b1;
                n_cnt = '0;
                n_sum = '0;
                if (!r_base) begin
                    n_base        = 1'b1;
                    n_best        = acc;
                    n_gain[r_idx] = gain_add(r_gain[r_idx], r_step[r_idx]);
                end else begin
                    if (r_rounds != 16'hFFFF) begin
                        n_rounds = r_rounds + 16'd1;
                    end
                    if (better) begin
                        n_best         = acc;
                        n_step[r_idx]  = scaled;
                        n_first[r_idx] = 1'b1;
                        n_idx          = nx;
                        n_gain[nx]     = gain_add(r_gain[nx], r_step[nx]);
                    end else if (r_first[r_idx]) begin
                        n_gain[r_idx]  = gain_sub2(r_gain[r_idx], r_step[r_idx]);
                        n_first[r_idx] = 1'b0;
                    end else begin
                        n_gain[r_idx]  = gain_add(r_gain[r_idx], r_step[r_idx]);
                        n_step[r_idx]  = scaled;
                        n_first[r_idx] = 1'b1;
                        n_idx          = nx;
                        n_gain[nx]     = gain_add(r_gain[nx], r_step[nx]);
                    end
                end
            end
        end

        o_result.gain_p        = n_gain[0];
        o_result.gain_i        = n_gain[1];
        o_result.gain_d        = n_gain[2];
        o_result.tuning_active = can_run(n_step[0], n_step[1], n_step[2], n_rounds);
        o_result.round_ended   = ended;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_gain[k] <= '0;
                r_step[k] <= {1'b0, RST_INIT_STEP};
            end
            r_first  <= '1;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_best   <= '1;
            r_base   <= 1'b0;
            r_rounds <= '0;
        end else if (i_restart) begin
            for (int k = 0; k < 3; k++) begin
                r_gain[k] <= i_cfg.init_gain[k];
                r_step[k] <= {1'b0, i_cfg.init_step[k]};
            end
            r_first  <= '1;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_best   <= '1;
            r_base   <= 1'b0;
            r_rounds <= '0;
        end else begin
            for (int k = 0; k < 3; k++) begin
                r_gain[k] <= n_gain[k];
                r_step[k] <= n_step[k];
            end
            r_first  <= n_first;
            r_idx    <= n_idx;
            r_cnt    <= n_cnt;
            r_sum    <= n_sum;
            r_best   <= n_best;
            r_base   <= n_base;
            r_rounds <= n_rounds;
        end
    end

    `TWG_ASSERT_ALWAYS(a_cnt_range, (r_cnt < ROUND_LEN), "sample count past round length")
    `TWG_ASSERT_SAME(a_end_run, o_result.round_ended, (i_adv && run), "stray round end")
    `TWG_ASSERT_NEXT(a_round_clears, (!i_restart && ended), (~|{r_cnt, r_sum}), "round not reset")
    `TWG_ASSERT_NEXT(a_best_down, (r_base && !i_restart), (r_best <= $past(r_best)), "best grew")
    `TWG_ASSERT_NEXT(a_idle_hold, (!i_adv && !i_restart), $stable({r_sum, r_idx, r_cnt}), "idle drift")

endmodule

`default_nettype wire

// File: sv/twiddle_gain_tuner.sv
// ----------------------------------------------------------------------------
// twiddle gain tuner
// tunes p, i and d gains by twiddle coordinate descent on error samples
// ----------------------------------------------------------------------------
// Each error sample transfer produces one result: the three gains after that
// sample, whether tuning is still running and whether the sample closed an
// evaluation round. The block takes one sample every clock cycle when the
// result side keeps up; each sample passes through the input register, then
// the result register. The whole per-sample update, including the one 32x16
// step scaling multiply at a round end, is combinational logic between those
// two registers. A configuration write to a defined index is registered in
// the configuration registers and then restarts the search from the written
// starting gains and steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twiddle_gain_tuner import twg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_error_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_gain_p,
    output logic signed [31:0] o_gain_i,
    output logic signed [31:0] o_gain_d,
    output logic               o_tuning_active,
    output logic               o_round_ended,
    input  logic               i_cfg_wr_en,
    input  logic [3:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    t_cfg    cfg;
    logic    restart;
    t_result result;
    logic    adv;

    logic        r_in_valid;
    logic [31:0] r_in_sample;
    logic        r_out_valid;
    t_result     r_out;

    twg_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_wr_en),
        .i_idx     (i_cfg_idx),
        .i_data    (i_cfg_data),
        .o_cfg     (cfg),
        .o_restart (restart)
    );

    twg_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_cfg     (cfg),
        .i_adv     (adv),
        .i_sample  (r_in_sample),
        .o_result  (result)
    );

    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_sample <= i_error_sample;
        end
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_gain_p        = $signed(r_out.gain_p);
    assign o_gain_i        = $signed(r_out.gain_i);
    assign o_gain_d        = $signed(r_out.gain_d);
    assign o_tuning_active = r_out.tuning_active;
    assign o_round_ended   = r_out.round_ended;

endmodule

`default_nettype wire
